[hw/rtl/pcpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpg_pkg
// Shared types, register indexes and trig table builders for the curve
// point generator.
// ----------------------------------------------------------------------------
package pcpg_pkg;

  // curve shapes selected by the curve_select register
  typedef enum logic [2:0] {
    CURVE_ASTROID = 3'd0,
    CURVE_CYCLOID = 3'd1,
    CURVE_HUYGENS = 3'd2,
    CURVE_HYPO    = 3'd3,
    CURVE_LINE    = 3'd4
  } curve_e;

  // configuration register indexes
  localparam logic [1:0] REG_CURVE_SELECT = 2'd0;
  localparam logic [1:0] REG_CENTER_X     = 2'd1;
  localparam logic [1:0] REG_CENTER_Y     = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned PIXEL_W    = 16;

  // fixed point constants (Q30)
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_PI      = 64'd3373259426;

  // first quadrant split into this many angle steps
  localparam int unsigned QUAD_STEPS = 128;

  typedef logic [31:0] q30_tab_t [QUAD_STEPS];

  // taylor series sine or cosine on the first quadrant, Q30, built at elaboration
  function automatic q30_tab_t make_trig_tab(input logic want_cos);
    q30_tab_t    tab;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] sp;
    logic [63:0] cp;
    logic [63:0] t;
    int          n;
    for (int j = 0; j < QUAD_STEPS; j++) begin
      a  = (64'(j) * Q30_HALF_PI) >> 7;
      a2 = (a * a) >> 30;
      sp = Q30_ONE;
      cp = Q30_ONE;
      for (n = 17; n >= 3; n = n - 2) begin
        t  = ((a2 * sp) >> 30) / 64'(n * (n - 1));
        sp = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
      end
      for (n = 16; n >= 2; n = n - 2) begin
        t  = ((a2 * cp) >> 30) / 64'(n * (n - 1));
        cp = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
      end
      t      = (a * sp) >> 30;
      tab[j] = want_cos ? cp[31:0] : t[31:0];
    end
    return tab;
  endfunction

endpackage

[hw/rtl/pcpg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpg_if
// Valid/ready channels of the curve point generator: sample requests,
// point results and configuration writes.
// ----------------------------------------------------------------------------
interface pcpg_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcpg_pkg::INDEX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

interface pcpg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcpg_pkg::PIXEL_W-1:0] pixel_x;
  logic signed [pcpg_pkg::PIXEL_W-1:0] pixel_y;
  logic                                point_valid;

  modport source (output valid, output pixel_x, output pixel_y, output point_valid,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input point_valid,
                  output ready);
endinterface

interface pcpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pcpg_pkg::CFG_IDX_W-1:0]  index;
  logic [pcpg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/parametric_curve_point_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parametric_curve_point_generator
// Maps a sample index to one pixel on an astroid, cycloid, huygens cycloid,
// hypocycloid or line, through a five stage fixed point pipeline.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | accepted when
//  cfg_i   | in  | index, data                          | valid && ready
//  req_i   | in  | sample_index                         | valid && ready
//  rsp_o   | out | pixel_x, pixel_y, point_valid        | valid && ready
//
// one request per clock while the result side is not stalled; each request
// passes in order through index decode, trig table, products, center add, truncate/saturate
// every stage holds its own valid bit and takes new data when empty or when
// the stage after it moves, so a stalled result blocks only what is behind it
// reset clears valid bits and loads curve 0 with center (200, 100)
// ----------------------------------------------------------------------------
module parametric_curve_point_generator #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcpg_cfg_if.sink    cfg_i,
  pcpg_in_if.sink     req_i,
  pcpg_out_if.source  rsp_o
);
  import pcpg_pkg::*;

  localparam int T   = TRIG_FRAC_BITS;
  localparam int TW  = T + 2;
  localparam int SQW = T + 1;
  localparam int CW  = T + 9;
  localparam int VW  = (2 * T + 14 > 52) ? 2 * T + 14 : 52;

  localparam q30_tab_t SIN_Q30 = make_trig_tab(1'b0);
  localparam q30_tab_t COS_Q30 = make_trig_tab(1'b1);

  localparam logic signed [VW-1:0] PI36 = VW'(64'd36 * Q30_PI);

  // configuration registers
  logic [2:0]  sel_q;
  logic [11:0] cx_q, cy_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 3'(CURVE_ASTROID);
      cx_q  <= 12'd200;
      cy_q  <= 12'd100;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CURVE_SELECT: sel_q <= cfg_i.data[2:0];
        REG_CENTER_X:     cx_q  <= cfg_i.data;
        REG_CENTER_Y:     cy_q  <= cfg_i.data;
        default:          ;
      endcase
    end
  end

  // stage enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5         = !v5_q || rsp_o.ready;
  assign en4         = !v4_q || en5;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign req_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= req_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: range check and phase indexes in 1/512 turn
  logic [9:0] k;
  logic [9:0] k6;
  logic       ok1_d, ok1_q;
  logic [2:0] sh1_q;
  logic [9:0] k1_q;
  logic [8:0] ua_d, ub_d, ua_q, ub_q;

  always_comb begin
    k     = req_i.sample_index;
    k6    = 10'(k * 10'd6);
    ok1_d = 1'b0;
    ua_d  = k[8:0];
    ub_d  = '0;
    case (sel_q)
      CURVE_ASTROID: begin
        ok1_d = 1'b1;
      end
      CURVE_CYCLOID: begin
        ok1_d = !k[9];
        ua_d  = k6[8:0];
      end
      CURVE_HUYGENS: begin
        ok1_d = 1'b1;
        ua_d  = {k[7:0], 1'b0};
        ub_d  = k6[8:0];
      end
      CURVE_HYPO: begin
        ok1_d = 1'b1;
        ub_d  = {k[7:0], 1'b0};
      end
      CURVE_LINE: begin
        ok1_d = !k[9];
      end
      default: ok1_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ok1_q <= ok1_d;
      sh1_q <= sel_q;
      k1_q  <= k;
      ua_q  <= ua_d;
      ub_q  <= ub_d;
    end
  end

  // stage 2: table lookup, rounding and quadrant folding
  function automatic logic [2*TW-1:0] trig_look(input logic [8:0] u);
    logic [31:0]          sv;
    logic [31:0]          cv;
    logic signed [TW-1:0] rs;
    logic signed [TW-1:0] rc;
    logic signed [TW-1:0] so;
    logic signed [TW-1:0] co;
    sv = SIN_Q30[u[6:0]];
    cv = COS_Q30[u[6:0]];
    rs = TW'((sv + (32'd1 << (29 - T))) >> (30 - T));
    rc = TW'((cv + (32'd1 << (29 - T))) >> (30 - T));
    case (u[8:7])
      2'd0:    begin so = rs;  co = rc;  end
      2'd1:    begin so = rc;  co = -rs; end
      2'd2:    begin so = -rs; co = -rc; end
      default: begin so = -rc; co = rs;  end
    endcase
    return {so, co};
  endfunction

  logic                 ok2_q;
  logic [2:0]           sh2_q;
  logic [9:0]           k2_q;
  logic signed [TW-1:0] sa_q, ca_q, sb_q, cb_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ok2_q        <= ok1_q;
      sh2_q        <= sh1_q;
      k2_q         <= k1_q;
      {sa_q, ca_q} <= trig_look(ua_q);
      {sb_q, cb_q} <= trig_look(ub_q);
    end
  end

  // stage 3: squares for the astroid, linear terms for the other shapes
  logic                  ok3_q;
  logic [2:0]            sh3_q;
  logic [SQW-1:0]        sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [CW-1:0]  c100_d, s100_d, c100_q, s100_q;
  logic signed [VW-1:0]  lx_d, ly_d, lx_q, ly_q;
  logic signed [2*TW-1:0] cc, ss;
  logic signed [VW-1:0]  ca_w, sa_w, cb_w, sb_w;
  logic signed [VW-1:0]  kc;

  always_comb begin
    cc     = ca_q * ca_q;
    ss     = sa_q * sa_q;
    sqx_d  = SQW'(cc >>> T);
    sqy_d  = SQW'(ss >>> T);
    c100_d = CW'(ca_q) * CW'(100);
    s100_d = CW'(sa_q) * CW'(100);
    ca_w   = VW'(ca_q);
    sa_w   = VW'(sa_q);
    cb_w   = VW'(cb_q);
    sb_w   = VW'(sb_q);
    kc     = VW'(signed'({1'b0, k2_q}));
    lx_d   = '0;
    ly_d   = '0;
    case (sh2_q)
      CURVE_CYCLOID: begin
        lx_d = VW'(6) * ((VW'(1) <<< T) - ca_w);
        ly_d = PI36 * (kc - VW'(256)) - VW'(6) * (sa_w <<< (38 - T));
      end
      CURVE_HUYGENS: begin
        lx_d = VW'(16) * (VW'(3) * ca_w - cb_w);
        ly_d = VW'(16) * (VW'(3) * sa_w - sb_w);
      end
      CURVE_HYPO: begin
        lx_d = VW'(30) * (VW'(2) * ca_w + cb_w);
        ly_d = VW'(30) * (VW'(2) * sa_w - sb_w);
      end
      CURVE_LINE: begin
        lx_d = VW'(50) * kc;
        ly_d = VW'(50) * kc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ok3_q  <= ok2_q;
      sh3_q  <= sh2_q;
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      c100_q <= c100_d;
      s100_q <= s100_d;
      lx_q   <= lx_d;
      ly_q   <= ly_d;
    end
  end

  // stage 4: astroid cube product and center add
  logic                 ok4_q;
  logic [2:0]           sh4_q;
  logic signed [VW-1:0] vx_d, vy_d, vx_q, vy_q;
  logic signed [VW-1:0] cxw, cyw;

  always_comb begin
    cxw = VW'(signed'({1'b0, cx_q}));
    cyw = VW'(signed'({1'b0, cy_q}));
    case (sh3_q)
      CURVE_ASTROID: begin
        vx_d = VW'(signed'({1'b0, sqx_q})) * VW'(c100_q) + (cxw <<< (2 * T));
        vy_d = VW'(signed'({1'b0, sqy_q})) * VW'(s100_q) + (cyw <<< (2 * T));
      end
      CURVE_CYCLOID: begin
        vx_d = lx_q + (cxw <<< T);
        vy_d = ly_q + (cyw <<< 38);
      end
      CURVE_LINE: begin
        vx_d = lx_q + (cxw <<< 8);
        vy_d = ly_q + (cyw <<< 8);
      end
      default: begin
        vx_d = lx_q + (cxw <<< T);
        vy_d = ly_q + (cyw <<< T);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ok4_q <= ok3_q;
      sh4_q <= sh3_q;
      vx_q  <= vx_d;
      vy_q  <= vy_d;
    end
  end

  // stage 5: truncate toward zero and saturate
  function automatic logic [PIXEL_W-1:0] to_pixel(input logic signed [VW-1:0] v,
                                                  input int unsigned f);
    logic [VW-1:0]      mag;
    logic [VW-1:0]      m;
    logic [PIXEL_W-1:0] r;
    mag = v[VW-1] ? VW'(-v) : VW'(v);
    m   = mag >> f;
    if (v[VW-1]) begin
      r = (m > VW'(32768)) ? 16'h8000 : PIXEL_W'(-m);
    end else begin
      r = (m > VW'(32767)) ? 16'h7fff : PIXEL_W'(m);
    end
    return r;
  endfunction

  logic [PIXEL_W-1:0] px_d, py_d, px_q, py_q;
  logic               pv_q;

  always_comb begin
    case (sh4_q)
      CURVE_ASTROID: begin
        px_d = to_pixel(vx_q, 2 * T);
        py_d = to_pixel(vy_q, 2 * T);
      end
      CURVE_CYCLOID: begin
        px_d = to_pixel(vx_q, T);
        py_d = to_pixel(vy_q, 38);
      end
      CURVE_LINE: begin
        px_d = to_pixel(vx_q, 8);
        py_d = to_pixel(vy_q, 8);
      end
      default: begin
        px_d = to_pixel(vx_q, T);
        py_d = to_pixel(vy_q, T);
      end
    endcase
    if (!ok4_q) begin
      px_d = '0;
      py_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      px_q <= px_d;
      py_q <= py_d;
      pv_q <= ok4_q;
    end
  end

  assign rsp_o.valid       = v5_q;
  assign rsp_o.pixel_x     = signed'(px_q);
  assign rsp_o.pixel_y     = signed'(py_q);
  assign rsp_o.point_valid = pv_q;

endmodule

[test/tb_parametric_curve_point_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parametric_curve_point_generator
// Self-checking bench for the curve point generator. Sample requests and
// register writes go in through the valid/ready channels, with random gaps on
// both sides and one long output stall. Every accepted request is turned into
// an expected pixel by a bit-accurate predictor, and results are checked in
// order, field by field.
// ----------------------------------------------------------------------------
module tb_parametric_curve_point_generator;
  import pcpg_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         DRAIN_CYCLES = 10;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               on_curve;
  } pixel_t;

  logic clk;
  logic rst_ni;
  int   n_errors;
  bit   no_idle;
  bit   long_hold;

  pcpg_cfg_if cfg_ch ();
  pcpg_in_if  req_ch ();
  pcpg_out_if rsp_ch ();

  parametric_curve_point_generator dut (
    .clk_i (clk),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  // one line per mismatch
  task automatic report(input string msg);
    n_errors++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // sine and cosine in Q15 from a 16-bit turn phase
  function automatic void sin_cos_q15(input logic [15:0] phase, output longint sn,
                                      output longint cs);
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] sp;
    logic [63:0] cp;
    logic [63:0] t;
    longint      s0;
    longint      c0;
    r  = 64'(phase[13:0]);
    a  = (r * Q30_HALF_PI) >> 14;
    a2 = (a * a) >> 30;
    sp = Q30_ONE;
    cp = Q30_ONE;
    for (int n = 17; n >= 3; n -= 2) begin
      t  = ((a2 * sp) >> 30) / 64'(n * (n - 1));
      sp = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    end
    for (int n = 16; n >= 2; n -= 2) begin
      t  = ((a2 * cp) >> 30) / 64'(n * (n - 1));
      cp = (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
    end
    t  = (a * sp) >> 30;
    s0 = longint'((t + 64'd16384) >> 15);
    c0 = longint'((cp + 64'd16384) >> 15);
    case (phase[15:14])
      2'd0: begin sn = s0;  cs = c0;  end
      2'd1: begin sn = c0;  cs = -s0; end
      2'd2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endfunction

  // drop f fraction bits toward zero, clamp to 16 bits signed
  function automatic logic signed [15:0] clamp_pixel(input longint v, input int f);
    logic [63:0] m;
    if (v < 0) begin
      m = (64'd0 - 64'(v)) >> f;
      if (m > 64'd32768) return -16'sd32768;
      return 16'(-longint'(m));
    end
    m = 64'(v) >> f;
    if (m > 64'd32767) return 16'sd32767;
    return 16'(m);
  endfunction

  // scoreboard: register shadow and queue of pending pixels
  class curve_scoreboard;
    logic [2:0]  curve_sel;
    logic [11:0] ctr_x;
    logic [11:0] ctr_y;
    pixel_t      pending[$];
    int          n_checked;

    function new();
      curve_sel = CURVE_ASTROID;
      ctr_x     = 12'd200;
      ctr_y     = 12'd100;
      n_checked = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [11:0] data);
      case (idx)
        REG_CURVE_SELECT: curve_sel = data[2:0];
        REG_CENTER_X:     ctr_x = data;
        REG_CENTER_Y:     ctr_y = data;
        default: ;
      endcase
    endfunction

    function pixel_t curve_point(input logic [9:0] idx);
      pixel_t      p;
      longint      k;
      longint      cx;
      longint      cy;
      longint      s;
      longint      c;
      longint      s2;
      longint      c2;
      longint      sq;
      logic [15:0] ph;
      k  = longint'(idx);
      cx = longint'(ctr_x);
      cy = longint'(ctr_y);
      p  = '0;
      case (curve_sel)
        CURVE_ASTROID: begin
          sin_cos_q15(16'({idx, 7'd0}), s, c);
          sq = (c * c) >>> 15;
          p.x = clamp_pixel(100 * sq * c + (cx <<< 30), 30);
          sq = (s * s) >>> 15;
          p.y = clamp_pixel(100 * sq * s + (cy <<< 30), 30);
          p.on_curve = 1'b1;
        end
        CURVE_CYCLOID: if (k < 512) begin
          sin_cos_q15(16'((32'(idx) * 3) << 8), s, c);
          p.x = clamp_pixel(6 * (32768 - c) + (cx <<< 15), 15);
          p.y = clamp_pixel(6 * (6 * longint'(Q30_PI) * (k - 256) - (s <<< 23))
                            + (cy <<< 38), 38);
          p.on_curve = 1'b1;
        end
        CURVE_HUYGENS: begin
          ph = 16'({idx, 8'd0});
          sin_cos_q15(ph, s, c);
          sin_cos_q15(16'(32'(ph) * 3), s2, c2);
          p.x = clamp_pixel(16 * (3 * c - c2) + (cx <<< 15), 15);
          p.y = clamp_pixel(16 * (3 * s - s2) + (cy <<< 15), 15);
          p.on_curve = 1'b1;
        end
        CURVE_HYPO: begin
          ph = 16'({idx, 7'd0});
          sin_cos_q15(ph, s, c);
          sin_cos_q15(16'(32'(ph) * 2), s2, c2);
          p.x = clamp_pixel(30 * (2 * c + c2) + (cx <<< 15), 15);
          p.y = clamp_pixel(30 * (2 * s - s2) + (cy <<< 15), 15);
          p.on_curve = 1'b1;
        end
        CURVE_LINE: if (k < 512) begin
          p.x = clamp_pixel(50 * k + (cx <<< 8), 8);
          p.y = clamp_pixel(50 * k + (cy <<< 8), 8);
          p.on_curve = 1'b1;
        end
        default: ;
      endcase
      return p;
    endfunction

    function void note_request(input logic [9:0] idx);
      pending.push_back(curve_point(idx));
    endfunction

    task check_point(input logic signed [15:0] x, input logic signed [15:0] y,
                     input logic on_curve);
      pixel_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected point (%0d, %0d) valid %0b", x, y, on_curve));
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (x !== e.x) report($sformatf("pixel_x %0d, want %0d", x, e.x));
      if (y !== e.y) report($sformatf("pixel_y %0d, want %0d", y, e.y));
      if (on_curve !== e.on_curve)
        report($sformatf("point_valid %0b, want %0b", on_curve, e.on_curve));
    endtask
  endclass

  curve_scoreboard sb = new();
  int              n_requests;
  int              n_writes;

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
  end

  // drive one sample request, then an optional gap
  task automatic send_sample(input logic [9:0] idx);
    int gap;
    req_ch.valid        <= 1'b1;
    req_ch.sample_index <= idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(idx);
    n_requests++;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, data);
    n_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] pick_center();
    case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  // result side: random ready gaps plus one long hold
  initial begin
    int w;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (120) @(posedge clk);
        long_hold = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      sb.check_point(rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.point_valid);
  end

  // stimulus
  initial begin
    logic [9:0] edge_idx[5] = '{10'd0, 10'd256, 10'd511, 10'd512, 10'd1023};
    logic [2:0] sel;
    n_errors     = 0;
    n_requests   = 0;
    n_writes     = 0;
    no_idle      = 1'b0;
    long_hold    = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.sample_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    @(posedge rst_ni);
    @(posedge clk);

    // directed: index edges on every shape, reset centers, then far centers
    foreach (edge_idx[i]) send_sample(edge_idx[i]);
    for (int cv = CURVE_CYCLOID; cv <= CURVE_LINE; cv++) begin
      write_reg(REG_CURVE_SELECT, 12'(cv));
      foreach (edge_idx[i]) send_sample(edge_idx[i]);
    end
    write_reg(REG_CENTER_X, 12'd4095);
    write_reg(REG_CENTER_Y, 12'd0);
    write_reg(REG_UNUSED, 12'hfff);
    send_sample(10'd0);
    send_sample(10'd1023);
    write_reg(REG_CURVE_SELECT, 12'hff7);
    send_sample(10'd100);

    // random phases, each with its own register setting
    for (int ph = 0; ph < 9; ph++) begin
      sel = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      write_reg(REG_CURVE_SELECT, {9'($urandom), sel});
      write_reg(REG_CENTER_X, pick_center());
      write_reg(REG_CENTER_Y, pick_center());
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 12'($urandom));
      no_idle   = (ph == 3);
      long_hold = (ph == 1);
      for (int i = 0; i < 220; i++) send_sample(10'($urandom));
    end
    no_idle = 1'b0;
    wait_drained();

    $display("ran %0d sample requests and %0d register writes over all curve shapes,",
             n_requests, n_writes);
    $display("%0d points checked, including a long output stall", sb.n_checked);
    if (n_errors == 0)
      $display("tb_parametric_curve_point_generator passed");
    else
      $display("tb_parametric_curve_point_generator failed");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 500000);
    $display("tb_parametric_curve_point_generator failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pcpg_pkg.sv
hw/rtl/pcpg_if.sv
hw/rtl/parametric_curve_point_generator.sv
test/tb_parametric_curve_point_generator.sv
